>>> hdl/page_replacement_fifo_second_chance_top_assert.svh
// Assertion macros shared by the frame-replacement RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PAGE_REPLACEMENT_FIFO_SECOND_CHANCE_TOP_ASSERT_SVH
`define PAGE_REPLACEMENT_FIFO_SECOND_CHANCE_TOP_ASSERT_SVH

// Condition holds at every edge.
`define PRFSC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PRFSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PRFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/prfsc_pkg.sv
// Shared constants and types for the frame-replacement block.
// No dependencies; imported by every module of the block.
package prfsc_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 8;
  localparam int SLOT_W     = 3;
  localparam int FRAMES_W   = 4;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'b1;

  localparam logic POLICY_FIFO   = 1'b0;
  localparam logic POLICY_SECOND = 1'b1;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(MAX_FRAMES);

  typedef struct packed {
    logic fill;
    logic set_ref;
    logic clr_ref;
  } tbl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]     total;
    logic [PAGE_BITS-1:0] ev_page;
    logic                 ev_valid;
    logic [SLOT_W-1:0]    slot;
    logic                 fault;
  } res_t;

endpackage

>>> hdl/page_replacement_fifo_second_chance_top.sv
// Flow: an accepted page is scanned from frame 0, one entry per cycle through a single
// comparator; a hit goes to RESULT, a fault places the page in the lowest empty frame
// or, after the hand clears set reference bits, at the hand; each result then passes
// through the result and output registers. A new page waits until the sequencer is idle.
// Reset (async, active low): frames empty, hand 0, fault count 0, FIFO, 8 frames.
// Top level: config registers, output register, sequencer and frame table.
module page_replacement_fifo_second_chance_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [prfsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [prfsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: page[7:0]
  input  logic [prfsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: fault[0], slot[3:1], evicted_valid[4], evicted_page[12:5],
  //        fault_total[28:13], zero[31:29]
  output logic [prfsc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import prfsc_pkg::*;

  logic                  policy_q;
  logic [FRAMES_W-1:0]   frames_q;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic [SLOT_W-1:0]     tbl_idx;
  tbl_cmd_t              tbl_cmd;
  logic [PAGE_BITS-1:0]  tbl_page;
  logic [PAGE_BITS-1:0]  rd_page;
  logic                  rd_valid;
  logic                  rd_ref;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIFO;
      frames_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POLICY: policy_q <= cfg_data_i[0];
        REG_FRAMES: frames_q <= cfg_data_i[FRAMES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  prfsc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .page_i      (s_axis_tdata[PAGE_BITS-1:0]),
    .policy_i    (policy_q),
    .frames_i    (frames_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .tbl_idx_o   (tbl_idx),
    .tbl_cmd_o   (tbl_cmd),
    .tbl_page_o  (tbl_page),
    .rd_page_i   (rd_page),
    .rd_valid_i  (rd_valid),
    .rd_ref_i    (rd_ref)
  );

  prfsc_frames u_frames (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .idx_i      (tbl_idx),
    .cmd_i      (tbl_cmd),
    .wr_page_i  (tbl_page),
    .rd_page_o  (rd_page),
    .rd_valid_o (rd_valid),
    .rd_ref_o   (rd_ref)
  );

  // output register frees the sequencer while a result waits downstream
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_DATA_W'(res);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/prfsc_frames.sv
// Frame table: page numbers, valid bits and reference bits, one port.
// Depends on prfsc_pkg.
module prfsc_frames (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [prfsc_pkg::SLOT_W-1:0]    idx_i,
  input  prfsc_pkg::tbl_cmd_t             cmd_i,
  input  logic [prfsc_pkg::PAGE_BITS-1:0] wr_page_i,
  output logic [prfsc_pkg::PAGE_BITS-1:0] rd_page_o,
  output logic                           rd_valid_o,
  output logic                           rd_ref_o
);
  import prfsc_pkg::*;

  logic [PAGE_BITS-1:0]  page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] ref_q;

  assign rd_page_o  = page_q[idx_i];
  assign rd_valid_o = valid_q[idx_i];
  assign rd_ref_o   = ref_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
    end else begin
      if (cmd_i.fill) begin
        valid_q[idx_i] <= 1'b1;
        ref_q[idx_i]   <= 1'b0;
      end else if (cmd_i.set_ref) begin
        ref_q[idx_i] <= 1'b1;
      end else if (cmd_i.clr_ref) begin
        ref_q[idx_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      page_q[idx_i] <= wr_page_i;
    end
  end

endmodule

>>> hdl/prfsc_seq.sv
// Sequencer: scans the frame table one entry per cycle with a single
// comparator, steps the clock hand and places faulting pages.
// Depends on prfsc_pkg and the assertion header.
module prfsc_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [prfsc_pkg::PAGE_BITS-1:0] page_i,
  input  logic                           policy_i,
  input  logic [prfsc_pkg::FRAMES_W-1:0]  frames_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output prfsc_pkg::res_t                 res_o,
  output logic [prfsc_pkg::SLOT_W-1:0]    tbl_idx_o,
  output prfsc_pkg::tbl_cmd_t             tbl_cmd_o,
  output logic [prfsc_pkg::PAGE_BITS-1:0] tbl_page_o,
  input  logic [prfsc_pkg::PAGE_BITS-1:0] rd_page_i,
  input  logic                           rd_valid_i,
  input  logic                           rd_ref_i
);
  import prfsc_pkg::*;
  `include "page_replacement_fifo_second_chance_top_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_FILL,
    ST_RESULT
  } state_e;

  state_e               state_q, state_d;
  logic [PAGE_BITS-1:0] pg_q, pg_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic [SLOT_W-1:0]    last_q, last_d;
  logic [SLOT_W-1:0]    hand_q, hand_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 empty_q, empty_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  res_t                 res_q, res_d;

  logic [FRAMES_W-1:0]  n_cfg;
  logic [SLOT_W-1:0]    last_cfg;
  logic                 hit;
  logic                 place;
  logic [SLOT_W-1:0]    p_slot;
  logic                 p_ev;
  logic [PAGE_BITS-1:0] p_evpage;
  logic [CNT_W-1:0]     cnt_inc;

  always_comb begin
    if (frames_i == '0) begin
      n_cfg = FRAMES_W'(1);
    end else if (frames_i > FRAMES_W'(MAX_FRAMES)) begin
      n_cfg = FRAMES_W'(MAX_FRAMES);
    end else begin
      n_cfg = frames_i;
    end
    last_cfg = SLOT_W'(n_cfg - FRAMES_W'(1));
  end

  assign hit     = rd_valid_i && (rd_page_i == pg_q);
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    pg_d      = pg_q;
    idx_d     = idx_q;
    last_d    = last_q;
    hand_d    = hand_q;
    slot_d    = slot_q;
    empty_d   = empty_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    tbl_idx_o = idx_q;
    tbl_cmd_o = '0;
    place     = 1'b0;
    p_slot    = slot_q;
    p_ev      = 1'b0;
    p_evpage  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pg_d    = page_i;
          idx_d   = '0;
          empty_d = 1'b0;
          last_d  = last_cfg;
          // a hand left beyond a shrunk table restarts at frame zero
          if (hand_q > last_cfg) begin
            hand_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tbl_idx_o = idx_q;
        if (hit) begin
          tbl_cmd_o.set_ref = (policy_i == POLICY_SECOND);
          res_d.fault    = 1'b0;
          res_d.slot     = idx_q;
          res_d.ev_valid = 1'b0;
          res_d.ev_page  = '0;
          res_d.total    = cnt_q;
          state_d        = ST_RESULT;
        end else begin
          // remember the lowest empty frame
          if (!rd_valid_i && !empty_q) begin
            empty_d = 1'b1;
            slot_d  = idx_q;
          end
          if (idx_q == last_q) begin
            state_d = (empty_q || !rd_valid_i) ? ST_FILL : ST_SWEEP;
          end else begin
            idx_d = idx_q + SLOT_W'(1);
          end
        end
      end
      ST_SWEEP: begin
        tbl_idx_o = hand_q;
        if ((policy_i == POLICY_SECOND) && rd_ref_i) begin
          tbl_cmd_o.clr_ref = 1'b1;
          hand_d = (hand_q == last_q) ? '0 : hand_q + SLOT_W'(1);
        end else begin
          place    = 1'b1;
          p_slot   = hand_q;
          p_ev     = 1'b1;
          p_evpage = rd_page_i;
        end
      end
      ST_FILL: begin
        tbl_idx_o = slot_q;
        place     = 1'b1;
        p_slot    = slot_q;
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (place) begin
      tbl_cmd_o.fill = 1'b1;
      hand_d         = (p_slot == last_q) ? '0 : p_slot + SLOT_W'(1);
      cnt_d          = cnt_inc;
      res_d.fault    = 1'b1;
      res_d.slot     = p_slot;
      res_d.ev_valid = p_ev;
      res_d.ev_page  = p_evpage;
      res_d.total    = cnt_inc;
      state_d        = ST_RESULT;
    end
  end

  assign tbl_page_o  = pg_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESULT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hand_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      last_q  <= '0;
      empty_q <= 1'b0;
      slot_q  <= '0;
      pg_q    <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      hand_q  <= hand_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      empty_q <= empty_d;
      slot_q  <= slot_d;
      pg_q    <= pg_d;
      res_q   <= res_d;
    end
  end

  `PRFSC_ASSERT_IMPL(a_hand_in_range, state_q != ST_IDLE, hand_q <= last_q, "hand beyond active frames")
  `PRFSC_ASSERT_IMPL(a_scan_in_range, state_q == ST_SCAN, idx_q <= last_q, "scan index beyond active frames")
  `PRFSC_ASSERT_IMPL(a_evict_is_fault, res_valid_o && res_q.ev_valid, res_q.fault, "eviction without fault")
  `PRFSC_ASSERT_NEXT(a_cnt_monotonic, 1'b1, cnt_q >= $past(cnt_q), "fault counter went down")

endmodule
